[hw/rtl/rqs_pkg.sv]
`default_nettype none
package rqs_pkg;

  localparam int KEY_W     = 32;
  localparam int IDX_W     = 6;
  localparam int DEPTH_DEF = 64;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    last_in;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic [IDX_W-1:0]        original_index;
    logic                    overflow;
    logic                    last_out;
  } out_t;

  // one stored record: key and its arrival position
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        idx;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_POP,
    ST_POP_WAIT,
    ST_PIVOT,
    ST_SCAN_I,
    ST_SCAN_J,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/rqs_ram.sv]
`default_nettype none
module rqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/record_quicksort_by_key.sv]
// Loading: one input word per cycle; in_ready is high only while collecting.
// Sorting: iterative Hoare quicksort on one record RAM and a range stack RAM;
//   each range passes ST_POP, ST_POP_WAIT and ST_PIVOT, then alternating i and j
//   scans, swaps (ST_SWAP_A, then ST_SWAP_B) and the pushes ST_PUSH_A, ST_PUSH_B.
// Emission: each result word is loaded in ST_EMIT_LD and held until out_ready.
// Reset (rst_n low, synchronous) clears count, stack pointer, overflow and the
//   handshake state; the record and range RAMs are not cleared.
`default_nettype none
module record_quicksort_by_key #(
  parameter int DEPTH = rqs_pkg::DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output      logic         in_ready,
  input  wire rqs_pkg::in_t in_data,
  output      logic         out_valid,
  input  wire logic         out_ready,
  output rqs_pkg::out_t     out_data
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int IW  = AW + 2;
  localparam int RW  = $bits(rqs_pkg::rec_t);
  localparam int SW  = 2 * AW;

  rqs_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        sp_r, sp_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [AW-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic signed [rqs_pkg::KEY_W-1:0] pivot_r, pivot_nxt;
  rqs_pkg::rec_t        rec_i_r, rec_i_nxt, rec_j_r, rec_j_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rqs_pkg::out_t        out_r, out_nxt;

  // record RAM port signals
  logic                 rec_we;
  logic [AW-1:0]        rec_waddr, rec_raddr;
  rqs_pkg::rec_t        rec_wdata;
  logic [RW-1:0]        rec_rraw;
  rqs_pkg::rec_t        rec_rd;

  // range stack port signals
  logic                 stk_we;
  logic [AW-1:0]        stk_waddr, stk_raddr;
  logic [SW-1:0]        stk_wdata, stk_rd;

  logic signed [IW-1:0] lo_s, hi_s, i_inc, j_dec;
  logic [CW-1:0]        cnt_m1, sp_m1;
  logic [AW:0]          mid_sum;

  rqs_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_rec_ram (
    .clk     (clk),
    .wr_en   (rec_we),
    .wr_addr (rec_waddr),
    .wr_data (RW'(rec_wdata)),
    .rd_addr (rec_raddr),
    .rd_data (rec_rraw)
  );

  rqs_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stk_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rd)
  );

  assign rec_rd    = rqs_pkg::rec_t'(rec_rraw);
  assign lo_s      = {2'b00, lo_r};
  assign hi_s      = {2'b00, hi_r};
  assign i_inc     = i_r + IW'(1);
  assign j_dec     = j_r - IW'(1);
  assign cnt_m1    = cnt_r - CW'(1);
  assign sp_m1     = sp_r - CW'(1);
  assign mid_sum   = {1'b0, stk_rd[SW-1:AW]} + {1'b0, stk_rd[AW-1:0]};

  assign in_ready  = (state_r == rqs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rqs_pkg::ST_IDLE;
      cnt_r       <= '0;
      sp_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sp_r        <= sp_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    pivot_r <= pivot_nxt;
    rec_i_r <= rec_i_nxt;
    rec_j_r <= rec_j_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sp_nxt        = sp_r;
    k_nxt         = k_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pivot_nxt     = pivot_r;
    rec_i_nxt     = rec_i_r;
    rec_j_nxt     = rec_j_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    rec_we        = 1'b0;
    rec_waddr     = cnt_r[AW-1:0];
    rec_wdata.key = in_data.key;
    rec_wdata.idx = rqs_pkg::IDX_W'(cnt_r);
    rec_raddr     = i_r[AW-1:0];
    stk_we        = 1'b0;
    stk_waddr     = sp_r[AW-1:0];
    stk_wdata     = {i_r[AW-1:0], hi_r};
    stk_raddr     = sp_m1[AW-1:0];

    case (state_r)
      rqs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (cnt_r < CW'(DEPTH)) begin
            rec_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_in) begin
            state_nxt = rqs_pkg::ST_INIT;
          end
        end
      end

      rqs_pkg::ST_INIT: begin
        sp_nxt = '0;
        if (cnt_r < CW'(2)) begin
          k_nxt     = '0;
          rec_raddr = '0;
          state_nxt = rqs_pkg::ST_EMIT_LD;
        end else begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {{AW{1'b0}}, cnt_m1[AW-1:0]};
          sp_nxt    = CW'(1);
          state_nxt = rqs_pkg::ST_POP;
        end
      end

      rqs_pkg::ST_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          rec_raddr = '0;
          state_nxt = rqs_pkg::ST_EMIT_LD;
        end else begin
          sp_nxt    = sp_m1;
          state_nxt = rqs_pkg::ST_POP_WAIT;
        end
      end

      rqs_pkg::ST_POP_WAIT: begin
        lo_nxt    = stk_rd[SW-1:AW];
        hi_nxt    = stk_rd[AW-1:0];
        i_nxt     = {2'b00, stk_rd[SW-1:AW]};
        j_nxt     = {2'b00, stk_rd[AW-1:0]};
        rec_raddr = mid_sum[AW:1];
        state_nxt = rqs_pkg::ST_PIVOT;
      end

      rqs_pkg::ST_PIVOT: begin
        pivot_nxt = rec_rd.key;
        rec_raddr = i_r[AW-1:0];
        state_nxt = rqs_pkg::ST_SCAN_I;
      end

      rqs_pkg::ST_SCAN_I: begin
        // read ahead at i+1 so that its record is ready for the next scan step
        if (i_r <= hi_s && rec_rd.key < pivot_r) begin
          i_nxt     = i_inc;
          rec_raddr = i_inc[AW-1:0];
        end else begin
          rec_i_nxt = rec_rd;
          rec_raddr = j_r[AW-1:0];
          state_nxt = rqs_pkg::ST_SCAN_J;
        end
      end

      rqs_pkg::ST_SCAN_J: begin
        if (j_r >= lo_s && rec_rd.key > pivot_r) begin
          j_nxt     = j_dec;
          rec_raddr = j_dec[AW-1:0];
        end else begin
          rec_j_nxt = rec_rd;
          if (i_r <= j_r) begin
            state_nxt = rqs_pkg::ST_SWAP_A;
          end else begin
            state_nxt = rqs_pkg::ST_PUSH_A;
          end
        end
      end

      rqs_pkg::ST_SWAP_A: begin
        rec_we    = 1'b1;
        rec_waddr = i_r[AW-1:0];
        rec_wdata = rec_j_r;
        state_nxt = rqs_pkg::ST_SWAP_B;
      end

      rqs_pkg::ST_SWAP_B: begin
        rec_we    = 1'b1;
        rec_waddr = j_r[AW-1:0];
        rec_wdata = rec_i_r;
        i_nxt     = i_inc;
        j_nxt     = j_dec;
        rec_raddr = i_inc[AW-1:0];
        if (i_inc <= j_dec) begin
          state_nxt = rqs_pkg::ST_SCAN_I;
        end else begin
          state_nxt = rqs_pkg::ST_PUSH_A;
        end
      end

      rqs_pkg::ST_PUSH_A: begin
        if (i_r < hi_s && sp_r < CW'(DEPTH)) begin
          stk_we    = 1'b1;
          stk_wdata = {i_r[AW-1:0], hi_r};
          sp_nxt    = sp_r + CW'(1);
        end
        state_nxt = rqs_pkg::ST_PUSH_B;
      end

      rqs_pkg::ST_PUSH_B: begin
        if (j_r > lo_s && sp_r < CW'(DEPTH)) begin
          stk_we    = 1'b1;
          stk_wdata = {lo_r, j_r[AW-1:0]};
          sp_nxt    = sp_r + CW'(1);
        end
        state_nxt = rqs_pkg::ST_POP;
      end

      rqs_pkg::ST_EMIT_LD: begin
        out_nxt.sorted_key     = rec_rd.key;
        out_nxt.original_index = rec_rd.idx;
        out_nxt.overflow       = ovf_r;
        out_nxt.last_out       = (k_r == cnt_m1);
        out_valid_nxt          = 1'b1;
        state_nxt              = rqs_pkg::ST_EMIT_WAIT;
      end

      rqs_pkg::ST_EMIT_WAIT: begin
        rec_raddr = k_r[AW-1:0] + AW'(1);
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_out) begin
            // set done: clear for the next set
            cnt_nxt   = '0;
            sp_nxt    = '0;
            ovf_nxt   = 1'b0;
            state_nxt = rqs_pkg::ST_IDLE;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = rqs_pkg::ST_EMIT_LD;
          end
        end
      end

      default: begin
        state_nxt = rqs_pkg::ST_IDLE;
      end
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("record count beyond depth");

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(DEPTH))
    else $error("range stack pointer beyond depth");

  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == rqs_pkg::ST_EMIT_WAIT))
    else $error("result word valid outside emission");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && out_r.last_out) |=> (in_ready && cnt_r == '0))
    else $error("block not cleared after final result word");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rqs_pkg::ST_SCAN_I) |-> (i_r >= lo_s && i_r <= hi_s + IW'(1)))
    else $error("left scan index outside range");

endmodule
`default_nettype wire
